// File: hdl/gba_pkg.sv
// ----------------------------------------------------------------------------
// gba_pkg
// shared types, codes and helpers of the group-by integer aggregator
// ----------------------------------------------------------------------------
package gba_pkg;

  localparam int GROUP_ENTRIES_DEF = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [2:0] OP_MIN   = 3'd0;
  localparam logic [2:0] OP_MAX   = 3'd1;
  localparam logic [2:0] OP_SUM   = 3'd2;
  localparam logic [2:0] OP_AVG   = 3'd3;
  localparam logic [2:0] OP_COUNT = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_AGG_OP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUPING = 2'd1;

  localparam logic OPC_MERGE = 1'b0;
  localparam logic OPC_DRAIN = 1'b1;

  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] group_key;
    logic signed [31:0] agg_value;
  } in_beat_t;

  typedef struct packed {
    logic               row_kind;
    logic signed [31:0] out_key;
    logic signed [31:0] aggregate;
    logic               last_row;
  } out_beat_t;

  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [31:0] agg;
    logic [31:0] cnt;
  } entry_t;

  typedef struct packed {
    logic        cmp;
    logic        upd;
    logic        shift;
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] value;
  } cell_ctl_t;

  function automatic logic [31:0] combine(input logic [2:0] op, input logic [31:0] old,
                                          input logic [31:0] v);
    logic [31:0] r;
    r = old;
    case (op)
      OP_MIN:          r = ($signed(v) < $signed(old)) ? v : old;
      OP_MAX:          r = ($signed(v) > $signed(old)) ? v : old;
      OP_SUM, OP_AVG:  r = old + v;
      OP_COUNT:        r = old + 32'd1;
      default:         r = old;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/group_by_integer_aggregator_top.sv
// ----------------------------------------------------------------------------
// group_by_integer_aggregator_top
// grouped min / max / sum / average / count over a ring of table cells
// ----------------------------------------------------------------------------
// Each cell holds one group. A merge beat passes the match state and the
// update state: the key is broadcast and compared in every cell, then the
// matching cell updates itself or the next free cell opens the group (groups
// fill from cell 0 upwards); with the table full, a drop row is sent instead.
// A drain rotates the whole ring once; in average mode each row with a nonzero
// count waits for the bit-serial divider, and output stalls hold it. Rows
// leave from cell 0 in table order and the table is back in place when the
// drain ends. One beat is in work at a time.
module group_by_integer_aggregator_top
  import gba_pkg::*;
#(
  parameter int GROUP_ENTRIES = GROUP_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_beat_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_beat_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int FW = $clog2(GROUP_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MATCH = 6'b000010,
    S_UPD   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t      state;
  logic [2:0]  agg_op;
  logic        grouping;
  logic [31:0] mkey;
  logic [31:0] mval;
  logic [FW-1:0] fill;
  logic [FW-1:0] idx;
  logic [31:0] row_val;
  logic [31:0] row_key;
  logic        row_last;

  cell_ctl_t ctl;
  entry_t    ents [GROUP_ENTRIES];
  logic [GROUP_ENTRIES-1:0] hits;
  logic      any_hit;
  logic      out_free;
  logic      div_start;
  logic      div_done;
  logic [31:0] div_q;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign any_hit   = |hits;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    ctl       = '0;
    ctl.op    = agg_op;
    ctl.key   = mkey;
    ctl.value = mval;
    ctl.cmp   = (state == S_MATCH);
    ctl.upd   = (state == S_UPD) && (any_hit || (fill < FW'(GROUP_ENTRIES)));
    ctl.shift = (state == S_DRAIN && !ents[0].used) || (state == S_EMIT && out_free);
  end

  for (genvar i = 0; i < GROUP_ENTRIES; i++) begin : g_cell
    gba_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .sel_new  ((fill == FW'(i)) && !any_hit),
      .shift_in (ents[(i + 1) % GROUP_ENTRIES]),
      .ent      (ents[i]),
      .hit      (hits[i])
    );
  end

  assign div_start = (state == S_DRAIN) && (idx != FW'(GROUP_ENTRIES)) && ents[0].used
                     && (agg_op == OP_AVG) && (ents[0].cnt != 32'd0);

  gba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ents[0].agg),
    .divisor  (ents[0].cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AGG_OP:   agg_op   <= cfg_data[2:0];
        REG_GROUPING: grouping <= cfg_data[0];
        default: ;
      endcase
    end
    if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mkey <= grouping ? in_data.group_key : 32'd0;
          mval <= in_data.agg_value;
          idx  <= '0;
          state <= (in_data.opcode == OPC_DRAIN) ? S_DRAIN : S_MATCH;
        end
      end
      S_MATCH: state <= S_UPD;
      S_UPD: begin
        if (any_hit) begin
          state <= S_IDLE;
        end else if (fill < FW'(GROUP_ENTRIES)) begin
          fill  <= fill + FW'(1);
          state <= S_IDLE;
        end else if (out_free) begin
          out_valid          <= 1'b1;
          out_data.row_kind  <= KIND_DROP;
          out_data.out_key   <= mkey;
          out_data.aggregate <= 32'd0;
          out_data.last_row  <= 1'b1;
          state              <= S_IDLE;
        end
      end
      S_DRAIN: begin
        if (idx == FW'(GROUP_ENTRIES)) begin
          state <= S_IDLE;
        end else if (!ents[0].used) begin
          idx <= idx + FW'(1);
        end else begin
          row_key  <= grouping ? ents[0].key : 32'd0;
          row_last <= (idx == fill - FW'(1));
          case (agg_op)
            OP_AVG:   row_val <= 32'd0;
            OP_COUNT: row_val <= ents[0].cnt;
            default:  row_val <= ents[0].agg;
          endcase
          state <= div_start ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          row_val <= div_q;
          state   <= S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid          <= 1'b1;
          out_data.row_kind  <= KIND_ROW;
          out_data.out_key   <= row_key;
          out_data.aggregate <= row_val;
          out_data.last_row  <= row_last;
          idx                <= idx + FW'(1);
          state              <= S_DRAIN;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state     <= S_IDLE;
      agg_op    <= OP_MIN;
      grouping  <= 1'b1;
      fill      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end
  end

  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> $onehot0(hits))
    else $error("more than one cell matched the key");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(GROUP_ENTRIES))
    else $error("fill count beyond table size");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free |=> out_valid)
    else $error("row lost on emit");

endmodule

// File: hdl/gba_cell.sv
// ----------------------------------------------------------------------------
// gba_cell
// one table entry: key match, in-place update and ring shift to its neighbour
// ----------------------------------------------------------------------------
module gba_cell
  import gba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      sel_new,
  input  entry_t    shift_in,
  output entry_t    ent,
  output logic      hit
);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= ent.used && (ent.key == ctl.key);
    end
    if (ctl.shift) begin
      ent <= shift_in;
    end else if (ctl.upd) begin
      if (hit) begin
        ent.agg <= combine(ctl.op, ent.agg, ctl.value);
        ent.cnt <= ent.cnt + 32'd1;
      end else if (sel_new) begin
        ent.used <= 1'b1;
        ent.key  <= ctl.key;
        ent.agg  <= ctl.value;
        ent.cnt  <= 32'd1;
      end
    end
    if (rst) begin
      ent.used <= 1'b0;
      hit      <= 1'b0;
    end
  end

endmodule

// File: hdl/gba_div.sv
// ----------------------------------------------------------------------------
// gba_div
// signed by unsigned restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module gba_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  step;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic        neg;
  logic [32:0] rem_sh;

  assign rem_sh   = {rem[31:0], quo[31]};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      busy <= 1'b1;
      step <= 5'd0;
      rem  <= 33'd0;
      neg  <= dividend[31];
      quo  <= dividend[31] ? (32'd0 - dividend) : dividend;
      dsr  <= divisor;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dsr}) begin
        rem <= rem_sh - {1'b0, dsr};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
      step <= step + 5'd1;
      if (step == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

endmodule

// File: test/group_by_integer_aggregator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_by_integer_aggregator_top_tb
// self-checking bench for the grouped min / max / sum / average / count block
// ----------------------------------------------------------------------------
// Merge and drain beats are queued by phase and driven with random gaps. A
// table model in the bench predicts every drain row and every dropped merge.
// Rows are checked field by field in order. Phases change the operation, the
// grouping mode and the handshake pressure, including one long output stall.
// ----------------------------------------------------------------------------
module group_by_integer_aggregator_top_tb;
  import gba_pkg::*;

  localparam int ENTRIES = GROUP_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int POOL_SIZE = 96;

  typedef struct {
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;
  } cfg_write_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_beat_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_beat_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;

  group_by_integer_aggregator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // table model
  logic        tbl_used [ENTRIES] = '{default: 1'b0};
  logic [31:0] tbl_key  [ENTRIES];
  logic [31:0] tbl_agg  [ENTRIES];
  logic [31:0] tbl_cnt  [ENTRIES];
  logic [2:0]  cur_op = OP_MIN;
  logic        cur_grouping = 1'b1;

  in_beat_t   pending_beats [$];
  out_beat_t  expected_rows [$];
  cfg_write_t pending_writes [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count = 0;
  int rows_seen = 0;
  int drops_seen = 0;
  int cycle_count = 0;
  bit hold_tgl;
  bit hold_seen;
  int hold_left;
  logic [31:0] key_pool [POOL_SIZE];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at cycle %0d: got %h, expected %h", field, cycle_count, got,
             want);
    mismatch_count++;
  endtask

  function automatic logic [31:0] merged_value(input logic [31:0] old, input logic [31:0] v);
    case (cur_op)
      OP_MIN:         return ($signed(v) < $signed(old)) ? v : old;
      OP_MAX:         return ($signed(v) > $signed(old)) ? v : old;
      OP_SUM, OP_AVG: return old + v;
      OP_COUNT:       return old + 32'd1;
      default:        return old;
    endcase
  endfunction

  function automatic logic [31:0] row_result(input int i);
    longint num;
    longint den;
    longint q;
    if (cur_op == OP_AVG) begin
      if (tbl_cnt[i] == 32'd0) return 32'd0;
      num = longint'($signed(tbl_agg[i]));
      den = longint'({32'd0, tbl_cnt[i]});
      q = num / den;
      return q[31:0];
    end
    if (cur_op == OP_COUNT) return tbl_cnt[i];
    return tbl_agg[i];
  endfunction

  task automatic predict_groups(input in_beat_t b);
    logic [31:0] k;
    int hit;
    int free_i;
    int last;
    out_beat_t r;
    hit = -1;
    free_i = -1;
    last = -1;
    if (b.opcode == OPC_MERGE) begin
      k = cur_grouping ? b.group_key : 32'd0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_used[i]) begin
          if (hit < 0 && tbl_key[i] == k) hit = i;
        end else if (free_i < 0) begin
          free_i = i;
        end
      end
      if (hit >= 0) begin
        tbl_agg[hit] = merged_value(tbl_agg[hit], b.agg_value);
        tbl_cnt[hit] = tbl_cnt[hit] + 32'd1;
      end else if (free_i >= 0) begin
        tbl_used[free_i] = 1'b1;
        tbl_key[free_i] = k;
        tbl_agg[free_i] = b.agg_value;
        tbl_cnt[free_i] = 32'd1;
      end else begin
        r.row_kind = KIND_DROP;
        r.out_key = k;
        r.aggregate = '0;
        r.last_row = 1'b1;
        expected_rows = {expected_rows, r};
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) if (tbl_used[i]) last = i;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_used[i]) begin
          r.row_kind = KIND_ROW;
          r.out_key = cur_grouping ? tbl_key[i] : 32'd0;
          r.aggregate = row_result(i);
          r.last_row = (i == last);
          expected_rows = {expected_rows, r};
        end
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) predict_groups(in_data);
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // configuration driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data <= '0;
    end else if (!cfg_valid || cfg_ready) begin
      if (cfg_valid) begin
        if (cfg_index == REG_AGG_OP) cur_op = cfg_data[2:0];
        else if (cfg_index == REG_GROUPING) cur_grouping = cfg_data[0];
      end
      if (pending_writes.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= pending_writes[0].index;
        cfg_data <= pending_writes[0].data;
        pending_writes.pop_front();
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // output ready with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    out_beat_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("unexpected output beat at cycle %0d: %h", cycle_count, out_data);
        mismatch_count++;
      end else begin
        w = expected_rows.pop_front();
        if (out_data.row_kind != w.row_kind)
          report_mismatch("row_kind", 32'(out_data.row_kind), 32'(w.row_kind));
        if (out_data.out_key != w.out_key) report_mismatch("out_key", out_data.out_key, w.out_key);
        if (out_data.aggregate != w.aggregate)
          report_mismatch("aggregate", out_data.aggregate, w.aggregate);
        if (out_data.last_row != w.last_row)
          report_mismatch("last_row", 32'(out_data.last_row), 32'(w.last_row));
        if (w.row_kind == KIND_DROP) drops_seen++;
        else rows_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
               expected_rows.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_beat(input logic opc, input logic [31:0] k, input logic [31:0] v);
    in_beat_t b;
    b.opcode = opc;
    b.group_key = k;
    b.agg_value = v;
    pending_beats = {pending_beats, b};
  endtask

  task automatic wait_quiet();
    while (pending_beats.size() > 0 || in_valid || expected_rows.size() > 0 ||
           pending_writes.size() > 0 || cfg_valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] op, input logic grp);
    cfg_write_t w;
    w.index = REG_AGG_OP;
    w.data = $urandom();
    w.data[2:0] = op;
    pending_writes = {pending_writes, w};
    w.index = REG_GROUPING;
    w.data = $urandom();
    w.data[0] = grp;
    pending_writes = {pending_writes, w};
    while (pending_writes.size() > 0 || cfg_valid) @(posedge clk);
  endtask

  task automatic queue_random(input int n, input int span);
    logic [31:0] k;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        queue_beat(OPC_DRAIN, $urandom(), $urandom());
      end else begin
        if ($urandom_range(99) < 10) k = $urandom();
        else k = key_pool[$urandom_range(span - 1)];
        if ($urandom_range(99) < 70) v = $urandom();
        else v = $urandom_range(40) - 20;
        queue_beat(OPC_MERGE, k, v);
      end
    end
    queue_beat(OPC_DRAIN, $urandom(), $urandom());
  endtask

  initial begin
    logic [2:0] ph_op   [9] = '{OP_MIN, OP_MAX, OP_SUM, OP_AVG, OP_COUNT, 3'd6, OP_AVG,
                               OP_SUM, 3'd7};
    logic       ph_grp  [9] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    int         ph_idle [9] = '{0, 61, 0, 26, 0, 61, 0, 26, 0};
    int         ph_stall[9] = '{0, 0, 61, 26, 0, 0, 61, 26, 0};
    int         ph_span [9] = '{8, 16, 24, 32, 48, 64, 80, 96, 96};
    rst = 1'b1;
    hold_tgl = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h7fff_ffff;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'd0;
    key_pool[3] = 32'hffff_ffff;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 9; p++) begin
      set_mode(ph_op[p], ph_grp[p]);
      send_idle_pct = ph_idle[p];
      recv_stall_pct = ph_stall[p];
      if (p == 0) begin
        // empty drain, extremes, repeat hits, shared key zero
        queue_beat(OPC_DRAIN, 32'h7fff_ffff, 32'h8000_0000);
        queue_beat(OPC_MERGE, 32'h7fff_ffff, 32'h8000_0000);
        queue_beat(OPC_MERGE, 32'h8000_0000, 32'h7fff_ffff);
        queue_beat(OPC_MERGE, 32'd0, 32'd5);
        queue_beat(OPC_MERGE, 32'hffff_ffff, 32'hffff_ffff);
        queue_beat(OPC_MERGE, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_beat(OPC_MERGE, 32'h8000_0000, 32'h8000_0000);
        queue_beat(OPC_MERGE, 32'd0, 32'hffff_fffb);
        queue_beat(OPC_DRAIN, 32'hffff_ffff, 32'hffff_ffff);
      end
      if (p == 3) begin
        // long output hold-off while the sender keeps pushing
        queue_beat(OPC_DRAIN, '0, '0);
        queue_beat(OPC_DRAIN, '0, '0);
        hold_tgl = ~hold_tgl;
      end
      queue_random(46, ph_span[p]);
      wait_quiet();
    end

    $display("%0d group rows and %0d dropped merges checked over 9 phases", rows_seen,
             drops_seen);
    $display("phases covered every operation, both grouping modes and a full table");
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/gba_pkg.sv
hdl/gba_cell.sv
hdl/gba_div.sv
hdl/group_by_integer_aggregator_top.sv
test/group_by_integer_aggregator_top_tb.sv
